/* rtl/core/gcd_pkg.sv */
// Shared types, constants and arithmetic helpers for the great-circle distance block.
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int RW = 34;
  localparam int VW = 36;
  localparam int AW = 32;

  localparam logic [0:0] REG_RADIUS    = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  localparam logic [19:0] LAT_LIMIT = 20'd324000;
  localparam logic [21:0] FULL_TURN = 22'd1296000;
  localparam logic [21:0] HALF_TURN = 22'd648000;
  localparam logic [21:0] QTR_TURN  = 22'd324000;
  localparam logic [37:0] PI_FRAC   = 38'd419426;
  localparam logic [37:0] HALF_DIV  = 38'd324000;
  localparam logic [30:0] PI_WHOLE  = 31'd5205;
  localparam logic [32:0] DIV_ODD   = 33'd10125;
  localparam logic [64:0] RECIP     = (65'd1 << 46) / 65'd10125;

  localparam logic signed [31:0] INV_GAIN = 32'sd652032874;
  localparam logic signed [VW-1:0] HALF_PI = 36'sd1686629713;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  localparam logic signed [VW-1:0] ATAN_HEAD [10] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158, 36'sd67021686,
    36'sd33543515, 36'sd16775850, 36'sd8388437, 36'sd4194282, 36'sd2097149
  };

  typedef struct packed {
    logic signed [AW-1:0] lat1;
    logic signed [AW-1:0] lat2;
    logic signed [AW-1:0] dlon;
    logic                 flip;
  } angle_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic signed [VW-1:0] atan_q30(input int i);
    logic signed [VW-1:0] r;
    if (i < 10) begin
      r = ATAN_HEAD[i];
    end else if (i <= 30) begin
      r = VW'((64'sd1 <<< (30 - i)) - 64'sd1);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic [63:0] m;
    logic [63:0] r;
    p = 64'(a) * 64'(b);
    m = p[63] ? 64'(-p) : 64'(p);
    r = (m + 64'd536870912) >> 30;
    return p[63] ? -$signed(r[33:0]) : $signed(r[33:0]);
  endfunction

endpackage
`default_nettype wire

/* rtl/core/great_circle_distance_top.sv */
// Top level of the great-circle distance block: configuration, front end, queue, back end.
// Throughput: one request per cycle while busy is low; the unrolled CORDIC stages set the pipeline depth.
// Results appear on done for one cycle each; the receiver cannot stall.
// Reset (rst, synchronous): empties the pipeline and queue, radius 6875, threshold 10000.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [19:0] first_lat_arcsec,
  input  wire logic signed [20:0] first_lon_arcsec,
  input  wire logic signed [19:0] second_lat_arcsec,
  input  wire logic signed [20:0] second_lon_arcsec,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic                    done,
  output logic [23:0]             distance_hundredths,
  output logic                    danger
);

  logic [15:0] radius_half_miles;
  logic [23:0] danger_threshold_hundredths;

  logic                   f_push;
  gcd_pkg::angle_item_t   f_item;
  gcd_pkg::angle_item_t   q_item;
  gcd_pkg::queue_status_t q_status;
  logic                   q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_half_miles <= 16'd6875;
      danger_threshold_hundredths <= 24'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcd_pkg::REG_RADIUS: radius_half_miles <= cfg_data[15:0];
        gcd_pkg::REG_THRESHOLD: danger_threshold_hundredths <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = q_status.full;
  assign q_pop = !q_status.empty;

  gcd_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(start && !busy),
    .first_lat_arcsec(first_lat_arcsec),
    .first_lon_arcsec(first_lon_arcsec),
    .second_lat_arcsec(second_lat_arcsec),
    .second_lon_arcsec(second_lon_arcsec),
    .push(f_push),
    .item(f_item)
  );

  gcd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(f_push),
    .wr_item(f_item),
    .pop(q_pop),
    .rd_item(q_item),
    .status(q_status)
  );

  gcd_back u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(q_pop),
    .in_item(q_item),
    .radius(radius_half_miles),
    .threshold(danger_threshold_hundredths),
    .out_valid(done),
    .distance(distance_hundredths),
    .danger(danger)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(f_push && q_status.full && !q_pop))
    else $error("request queue overflow");

  a_danger: assert property (@(posedge clk) disable iff (rst)
    done |-> (danger == (distance_hundredths < danger_threshold_hundredths)))
    else $error("danger flag disagrees with distance");

  a_quiet_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !done)
    else $error("result strobe right after reset");

endmodule
`default_nettype wire

/* rtl/core/gcd_front.sv */
// Front end: registers requests, folds positions and converts arc-seconds to Q2.30 radians.
`timescale 1ns / 1ps
`default_nettype none
module gcd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic signed [19:0]  first_lat_arcsec,
  input  wire logic signed [20:0]  first_lon_arcsec,
  input  wire logic signed [19:0]  second_lat_arcsec,
  input  wire logic signed [20:0]  second_lon_arcsec,
  output logic                     push,
  output gcd_pkg::angle_item_t     item
);

  localparam int AW_C = gcd_pkg::AW;

  logic v1, v2, v3;
  logic signed [19:0] lat1_r, lat2_r;
  logic signed [20:0] lon1_r, lon2_r;

  logic [18:0] mag [3];
  logic        neg [3];
  logic        flip_c;

  logic [18:0] mag2 [3];
  logic        neg2 [3];
  logic        flip2;

  logic [37:0] n3 [3];
  logic [30:0] base3 [3];
  logic        neg3 [3];
  logic        flip3;

  logic [31:0] np4 [3];
  logic [18:0] q4 [3];
  logic [30:0] base4 [3];
  logic        neg4 [3];
  logic        flip4;
  logic        v4;

  logic signed [AW_C-1:0] ang [3];

  logic signed [19:0] cl1, cl2;
  logic signed [21:0] dd;
  logic [21:0] ad, w1, f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      push <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      push <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      lat1_r <= first_lat_arcsec;
      lon1_r <= first_lon_arcsec;
      lat2_r <= second_lat_arcsec;
      lon2_r <= second_lon_arcsec;
    end
  end

  always_comb begin
    cl1 = (lat1_r > $signed(gcd_pkg::LAT_LIMIT)) ? $signed(gcd_pkg::LAT_LIMIT) :
          (lat1_r < -$signed(gcd_pkg::LAT_LIMIT)) ? -$signed(gcd_pkg::LAT_LIMIT) : lat1_r;
    cl2 = (lat2_r > $signed(gcd_pkg::LAT_LIMIT)) ? $signed(gcd_pkg::LAT_LIMIT) :
          (lat2_r < -$signed(gcd_pkg::LAT_LIMIT)) ? -$signed(gcd_pkg::LAT_LIMIT) : lat2_r;
    mag[0] = cl1[19] ? 19'(-cl1) : 19'(cl1);
    neg[0] = cl1[19];
    mag[1] = cl2[19] ? 19'(-cl2) : 19'(cl2);
    neg[1] = cl2[19];
    dd = 22'(lon2_r) - 22'(lon1_r);
    ad = dd[21] ? 22'(-dd) : 22'(dd);
    w1 = (ad >= gcd_pkg::FULL_TURN) ? ad - gcd_pkg::FULL_TURN : ad;
    f1 = (w1 > gcd_pkg::HALF_TURN) ? gcd_pkg::FULL_TURN - w1 : w1;
    flip_c = f1 > gcd_pkg::QTR_TURN;
    mag[2] = flip_c ? 19'(gcd_pkg::HALF_TURN - f1) : 19'(f1);
    neg[2] = 1'b0;
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [32:0] rem;
      logic [19:0] qc;
      logic [31:0] r;
      rem = 33'(np4[l]) - 33'(q4[l]) * gcd_pkg::DIV_ODD;
      qc = 20'(q4[l]) + 20'(rem >= gcd_pkg::DIV_ODD);
      r = 32'(base4[l]) + 32'(qc);
      ang[l] = neg4[l] ? -$signed(r) : $signed(r);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      logic [64:0] p;
      mag2[l] <= mag[l];
      neg2[l] <= neg[l];
      n3[l] <= 38'(mag2[l]) * gcd_pkg::PI_FRAC + gcd_pkg::HALF_DIV;
      base3[l] <= 31'(31'(mag2[l]) * gcd_pkg::PI_WHOLE);
      neg3[l] <= neg2[l];
      p = 65'(n3[l][37:6]) * gcd_pkg::RECIP;
      np4[l] <= n3[l][37:6];
      q4[l] <= p[64:46];
      base4[l] <= base3[l];
      neg4[l] <= neg3[l];
    end
    flip2 <= flip_c;
    flip3 <= flip2;
    flip4 <= flip3;
    item.lat1 <= ang[0];
    item.lat2 <= ang[1];
    item.dlon <= ang[2];
    item.flip <= flip4;
  end

endmodule
`default_nettype wire

/* rtl/core/gcd_queue.sv */
// Two-entry request queue between the front end and the CORDIC back end.
`timescale 1ns / 1ps
`default_nettype none
module gcd_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire gcd_pkg::angle_item_t wr_item,
  input  wire logic                 pop,
  output gcd_pkg::angle_item_t      rd_item,
  output gcd_pkg::queue_status_t    status
);

  gcd_pkg::angle_item_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_item;
    end
  end

  assign rd_item = entry[rd_ptr];
  assign status.full = count == 2'd2;
  assign status.empty = count == 2'd0;

endmodule
`default_nettype wire

/* rtl/core/gcd_back.sv */
// Back end: pipelined CORDIC sine/cosine, products, atan2/hypot and radius scaling.
`timescale 1ns / 1ps
`default_nettype none
module gcd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire gcd_pkg::angle_item_t in_item,
  input  wire logic [15:0]          radius,
  input  wire logic [23:0]          threshold,
  output logic                      out_valid,
  output logic [23:0]               distance,
  output logic                      danger
);

  localparam int CI = gcd_pkg::CORDIC_ITERATIONS;
  localparam int RW = gcd_pkg::RW;
  localparam int VW = gcd_pkg::VW;
  localparam int L = 3 * CI + 8;

  logic [L-1:0] pv;

  logic signed [RW-1:0] rx [CI+1][3];
  logic signed [RW-1:0] ry [CI+1][3];
  logic signed [RW-1:0] rz [CI+1][3];
  logic                 rflip [CI+1];

  logic signed [33:0] a1, t1, u1, v1, w1;
  logic signed [31:0] cd1;

  logic signed [VW-1:0] vx1 [CI+1];
  logic signed [VW-1:0] vy1 [CI+1];
  logic signed [33:0]   vc1 [CI+1];

  logic signed [33:0] h_r, c_r;

  logic signed [VW-1:0] wx [CI+1];
  logic signed [VW-1:0] wy [CI+1];
  logic signed [VW-1:0] wz [CI+1];
  logic                 wzero [CI+1];
  logic                 woff [CI+1];

  logic [31:0] theta;
  logic [23:0] dist_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[L-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rx[0][0] <= RW'(gcd_pkg::INV_GAIN);
    rx[0][1] <= RW'(gcd_pkg::INV_GAIN);
    rx[0][2] <= RW'(gcd_pkg::INV_GAIN);
    ry[0][0] <= '0;
    ry[0][1] <= '0;
    ry[0][2] <= '0;
    rz[0][0] <= RW'(in_item.lat1);
    rz[0][1] <= RW'(in_item.lat2);
    rz[0][2] <= RW'(in_item.dlon);
    rflip[0] <= in_item.flip;
  end

  for (genvar i = 0; i < CI; i++) begin : g_rot
    always_ff @(posedge clk) begin
      rflip[i+1] <= rflip[i];
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (rz[i][l] >= 0) begin
          rx[i+1][l] <= rx[i][l] - (ry[i][l] >>> i);
          ry[i+1][l] <= ry[i][l] + (rx[i][l] >>> i);
          rz[i+1][l] <= rz[i][l] - RW'(gcd_pkg::atan_q30(i));
        end else begin
          rx[i+1][l] <= rx[i][l] + (ry[i][l] >>> i);
          ry[i+1][l] <= ry[i][l] - (rx[i][l] >>> i);
          rz[i+1][l] <= rz[i][l] + RW'(gcd_pkg::atan_q30(i));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    a1 <= gcd_pkg::mulq(rx[CI][1][31:0], ry[CI][2][31:0]);
    t1 <= gcd_pkg::mulq(rx[CI][0][31:0], ry[CI][1][31:0]);
    u1 <= gcd_pkg::mulq(ry[CI][0][31:0], rx[CI][1][31:0]);
    v1 <= gcd_pkg::mulq(ry[CI][0][31:0], ry[CI][1][31:0]);
    w1 <= gcd_pkg::mulq(rx[CI][0][31:0], rx[CI][1][31:0]);
    cd1 <= rflip[CI] ? -rx[CI][2][31:0] : rx[CI][2][31:0];
  end

  always_ff @(posedge clk) begin
    vx1[0] <= VW'(a1);
    vy1[0] <= VW'(t1) - VW'(gcd_pkg::mulq(u1[31:0], cd1));
    vc1[0] <= v1 + gcd_pkg::mulq(w1[31:0], cd1);
  end

  for (genvar i = 0; i < CI; i++) begin : g_vec1
    always_ff @(posedge clk) begin
      vc1[i+1] <= vc1[i];
      if (vy1[i] >= 0) begin
        vx1[i+1] <= vx1[i] + (vy1[i] >>> i);
        vy1[i+1] <= vy1[i] - (vx1[i] >>> i);
      end else begin
        vx1[i+1] <= vx1[i] - (vy1[i] >>> i);
        vy1[i+1] <= vy1[i] + (vx1[i] >>> i);
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r <= gcd_pkg::mulq(vx1[CI][31:0], gcd_pkg::INV_GAIN);
    c_r <= vc1[CI];
  end

  always_ff @(posedge clk) begin
    wzero[0] <= (h_r == 34'sd0) && (c_r == 34'sd0);
    woff[0] <= c_r < 0;
    wz[0] <= '0;
    if (c_r >= 0) begin
      wx[0] <= VW'(c_r);
      wy[0] <= VW'(h_r);
    end else begin
      wx[0] <= VW'(h_r);
      wy[0] <= -VW'(c_r);
    end
  end

  for (genvar i = 0; i < CI; i++) begin : g_vec2
    always_ff @(posedge clk) begin
      wzero[i+1] <= wzero[i];
      woff[i+1] <= woff[i];
      if (wy[i] >= 0) begin
        wx[i+1] <= wx[i] + (wy[i] >>> i);
        wy[i+1] <= wy[i] - (wx[i] >>> i);
        wz[i+1] <= wz[i] + gcd_pkg::atan_q30(i);
      end else begin
        wx[i+1] <= wx[i] - (wy[i] >>> i);
        wy[i+1] <= wy[i] + (wx[i] >>> i);
        wz[i+1] <= wz[i] - gcd_pkg::atan_q30(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [VW-1:0] t;
    logic [21:0] r50;
    logic [54:0] prod;
    logic [24:0] d;
    t = wz[CI] + (woff[CI] ? gcd_pkg::HALF_PI : '0);
    theta <= (wzero[CI] || t < 0) ? 32'd0 : t[31:0];
    r50 = 22'(radius) * 22'd50;
    prod = 55'(theta) * 55'(r50) + 55'd536870912;
    d = prod[54:30];
    dist_r <= d[24] ? gcd_pkg::DIST_MAX : d[23:0];
    distance <= dist_r;
    danger <= dist_r < threshold;
  end

  assign out_valid = pv[L-1];

endmodule
`default_nettype wire
